// ----- src/positional_ordered_list_unit_assert.svh -----
// assertion macros for the ordered list unit
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define POL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define POL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/pol_pkg.sv -----
`default_nettype none

package pol_pkg;

    localparam int unsigned DEPTH_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_INSERT_HEAD = 2'd0;
    localparam logic [1:0] CMD_INSERT_TAIL = 2'd1;
    localparam logic [1:0] CMD_INSERT_AT   = 2'd2;
    localparam logic [1:0] CMD_DELETE_AT   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_POS = 2'd3;

    // operation broadcast to every cell
    localparam logic [1:0] OP_NOP     = 2'd0;
    localparam logic [1:0] OP_INS_AT  = 2'd1;
    localparam logic [1:0] OP_INS_TAIL = 2'd2;
    localparam logic [1:0] OP_DEL_AT  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         pos_m1;
        logic signed [31:0] value;
    } t_cell_op;

endpackage

`default_nettype wire

// ----- src/pol_cell.sv -----
`default_nettype none

module pol_cell #(
    parameter int IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pol_pkg::t_cell_op  i_op,
    input  wire logic signed [31:0] i_left_data,
    input  wire logic               i_left_last,
    input  wire logic signed [31:0] i_right_data,
    input  wire logic               i_right_last,
    output logic signed [31:0]      o_data,
    output logic                    o_last
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_last;
    logic               n_last;

    always_comb begin
        n_data = r_data;
        n_last = r_last;
        case (i_op.kind) inside
            pol_pkg::OP_INS_AT: begin
                if (IDX == int'(i_op.pos_m1)) begin
                    n_data = i_op.value;
                end else if (IDX > int'(i_op.pos_m1)) begin
                    n_data = i_left_data;
                end
            end
            pol_pkg::OP_INS_TAIL: begin
                if (i_left_last) begin
                    n_data = i_op.value;
                end
            end
            pol_pkg::OP_DEL_AT: begin
                if (IDX >= int'(i_op.pos_m1)) begin
                    n_data = i_right_data;
                end
            end
            default: ;
        endcase
        // last marker moves with the shift direction
        case (i_op.kind) inside
            pol_pkg::OP_INS_AT, pol_pkg::OP_INS_TAIL: n_last = i_left_last;
            pol_pkg::OP_DEL_AT:                       n_last = i_right_last;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else begin
            r_last <= n_last;
        end
    end

    assign o_data = r_data;
    assign o_last = r_last;

endmodule

`default_nettype wire

// ----- src/positional_ordered_list_unit.sv -----
// Bounded ordered list of up to DEPTH signed 32-bit values held in a row of
// cells, cell 0 being position 1. Each item is a command: insert at head,
// insert at tail, insert at a 1-based position, or delete at a 1-based
// position. Every item returns one result item with a status (ok, full,
// empty, bad position), the length after the command and the head and tail
// values (zero when the list is empty). Rejected commands leave the list
// unchanged. An accepted item updates all cells at once at its accept edge:
// each cell either keeps its value, loads the new value, or takes the value
// of its left or right neighbor, and a one-hot marker of the last entry
// shifts along with the data. The result then goes through a select stage
// that picks the tail out of the marked cell into the output register, and
// waits as pending while that register is held. A new item is taken in every
// cycle in which the pending result can move into the output register, so the
// sustained rate is one item per cycle when results are taken promptly.
// Only positions 1..31 can be named by the 5-bit position field; length is
// reported modulo 32.
`default_nettype none

`include "positional_ordered_list_unit_assert.svh"

module positional_ordered_list_unit #(
    parameter int unsigned DEPTH = pol_pkg::DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [4:0]         i_position,
    input  wire logic signed [31:0] i_value,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic [4:0]              o_length,
    output logic signed [31:0]      o_head_value,
    output logic signed [31:0]      o_tail_value
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // list length
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // result waiting for the tail select stage
    logic               r_pend;
    logic [1:0]         r_pend_status;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [4:0]         r_out_length;
    logic signed [31:0] r_out_head;
    logic signed [31:0] r_out_tail;

    logic               w_in_acc;
    logic               w_load;
    logic               w_full;
    logic [1:0]         w_status;
    pol_pkg::t_cell_op  w_op;
    pol_pkg::t_cell_op  w_cell_op;

    logic signed [31:0] w_data [DEPTH];
    logic [DEPTH-1:0]   w_last;
    logic signed [31:0] w_tail;
    logic signed [31:0] w_head;

    // accepted insert that passed its checks, and the length it should reach
    logic               w_ins_ok;
    logic [CNT_W-1:0]   w_count_inc;

    // pending result moves out when the output register is free or drains
    assign w_load     = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend || w_load;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));

    // command check and decode against the current length
    always_comb begin
        w_status     = pol_pkg::ST_OK;
        w_op.kind    = pol_pkg::OP_NOP;
        w_op.pos_m1  = '0;
        w_op.value   = i_value;
        if (i_cmd != pol_pkg::CMD_DELETE_AT) begin
            // full check wins over position check
            if (w_full) begin
                w_status = pol_pkg::ST_FULL;
            end else if (i_cmd == pol_pkg::CMD_INSERT_HEAD) begin
                w_op.kind = pol_pkg::OP_INS_AT;
            end else if (i_cmd == pol_pkg::CMD_INSERT_TAIL) begin
                w_op.kind = pol_pkg::OP_INS_TAIL;
            end else if (i_position == '0 ||
                         int'(i_position) > int'(r_count) + 1) begin
                w_status = pol_pkg::ST_BAD_POS;
            end else begin
                w_op.kind   = pol_pkg::OP_INS_AT;
                w_op.pos_m1 = i_position - 5'd1;
            end
        end else begin
            // empty check wins over position check
            if (r_count == '0) begin
                w_status = pol_pkg::ST_EMPTY;
            end else if (i_position == '0 ||
                         int'(i_position) > int'(r_count)) begin
                w_status = pol_pkg::ST_BAD_POS;
            end else begin
                w_op.kind   = pol_pkg::OP_DEL_AT;
                w_op.pos_m1 = i_position - 5'd1;
            end
        end
    end

    // cells only see the operation when the item is really taken
    always_comb begin
        w_cell_op = w_op;
        if (!w_in_acc) begin
            w_cell_op.kind = pol_pkg::OP_NOP;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_in_acc) begin
            case (w_op.kind) inside
                pol_pkg::OP_INS_AT, pol_pkg::OP_INS_TAIL: n_count = r_count + CNT_W'(1);
                pol_pkg::OP_DEL_AT:                       n_count = r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

    // row of cells; the empty flag stands in as the last marker left of cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left_data;
        logic               w_left_last;
        logic signed [31:0] w_right_data;
        logic               w_right_last;

        if (g == 0) begin : g_first
            assign w_left_data = '0;
            assign w_left_last = (r_count == '0);
        end else begin : g_inner_left
            assign w_left_data = w_data[g-1];
            assign w_left_last = w_last[g-1];
        end

        if (g == DEPTH - 1) begin : g_final
            assign w_right_data = '0;
            assign w_right_last = 1'b0;
        end else begin : g_inner_right
            assign w_right_data = w_data[g+1];
            assign w_right_last = w_last[g+1];
        end

        pol_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_cell_op),
            .i_left_data  (w_left_data),
            .i_left_last  (w_left_last),
            .i_right_data (w_right_data),
            .i_right_last (w_right_last),
            .o_data       (w_data[g]),
            .o_last       (w_last[g])
        );
    end

    // tail select from the one-hot last marker; all zero when empty
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < int'(DEPTH); i++) begin
            w_tail = w_tail | (w_data[i] & {32{w_last[i]}});
        end
    end

    assign w_head = (r_count == '0) ? '0 : w_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend_status <= w_status;
        end
        if (w_load) begin
            r_out_status <= r_pend_status;
            r_out_length <= 5'(r_count);
            r_out_head   <= w_head;
            r_out_tail   <= w_tail;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_length     = r_out_length;
    assign o_head_value = r_out_head;
    assign o_tail_value = r_out_tail;

    assign w_ins_ok    = w_in_acc && (w_status == pol_pkg::ST_OK) &&
                         (i_cmd != pol_pkg::CMD_DELETE_AT);
    assign w_count_inc = r_count + CNT_W'(1);

    // at most one cell carries the last marker
    `POL_ASSERT(a_last_onehot, $onehot0(w_last), "last marker not one-hot")
    // marker present exactly when the list holds entries
    `POL_ASSERT(a_last_vs_count, (r_count == '0) == (w_last == '0), "last marker vs length")
    // length never grows past the depth
    `POL_ASSERT(a_count_bound, int'(r_count) <= int'(DEPTH), "length beyond depth")
    // an accepted good insert grows the list by one
    `POL_ASSERT(a_insert_grows, w_ins_ok |=> (r_count == $past(w_count_inc)), "insert no growth")

endmodule

`default_nettype wire

// ----- dv/positional_ordered_list_unit_tb.sv -----
`timescale 1ns / 1ps

module positional_ordered_list_unit_tb;

    import pol_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    // one command item and the result item it produces
    typedef struct {
        logic [1:0]         cmd;
        logic [4:0]         pos;
        logic signed [31:0] value;
    } t_list_cmd;

    typedef struct {
        logic [1:0]         status;
        logic [4:0]         length;
        logic signed [31:0] head;
        logic signed [31:0] tail;
    } t_list_view;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_cmd = CMD_INSERT_HEAD;
    logic [4:0]         i_position = 5'd0;
    logic signed [31:0] i_value = 32'sd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [4:0]         o_length;
    logic signed [31:0] o_head_value;
    logic signed [31:0] o_tail_value;

    positional_ordered_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_head_value (o_head_value),
        .o_tail_value (o_tail_value)
    );

    always #5 i_clk = ~i_clk;

    // commands waiting to be offered, and list views still owed by the block
    t_list_cmd  cmd_q[$];
    t_list_view view_q[$];

    // shadow copy of the list contents, position 1 at index 0
    logic signed [31:0] shadow_vals [0:LIST_DEPTH-1];
    int                 shadow_len = 0;
    int                 peak_len = 0;

    // handshake bookkeeping used by the clocked processes
    bit cmd_taken = 1'b0;
    bit hold_off = 1'b0;
    int cmd_gap = 0;
    int view_stall = 0;

    // run statistics
    int n_cmds = 0;
    int n_views = 0;
    int n_mismatch = 0;
    int n_status [0:3] = '{0, 0, 0, 0};

    // idling is on in alternating bands of the remaining stimulus, off near the end
    function automatic bit idling_on(int left);
        return left >= 60 && ((left / 50) % 2 == 0);
    endfunction

    // shadow update: applies one command and returns the list view after it
    task automatic apply_list_cmd(input t_list_cmd c, output t_list_view v);
        int p;
        int slot;
        int k;
        p = c.pos;
        v.status = ST_OK;
        if (c.cmd != CMD_DELETE_AT) begin
            // full check wins over the position check
            if (shadow_len >= LIST_DEPTH) begin
                v.status = ST_FULL;
            end else begin
                if (c.cmd == CMD_INSERT_HEAD) slot = 0;
                else if (c.cmd == CMD_INSERT_TAIL) slot = shadow_len;
                else if (p < 1 || p > shadow_len + 1) slot = -1;
                else slot = p - 1;
                if (slot < 0) begin
                    v.status = ST_BAD_POS;
                end else begin
                    // open a hole at slot, later entries move toward the tail
                    for (k = shadow_len; k > slot; k--) shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[slot] = c.value;
                    shadow_len++;
                end
            end
        end else begin
            // empty check wins over the position check
            if (shadow_len == 0) begin
                v.status = ST_EMPTY;
            end else if (p < 1 || p > shadow_len) begin
                v.status = ST_BAD_POS;
            end else begin
                for (k = p - 1; k + 1 < shadow_len; k++) shadow_vals[k] = shadow_vals[k+1];
                shadow_len--;
            end
        end
        if (shadow_len > peak_len) peak_len = shadow_len;
        v.length = shadow_len[4:0];
        v.head = (shadow_len == 0) ? 32'sd0 : shadow_vals[0];
        v.tail = (shadow_len == 0) ? 32'sd0 : shadow_vals[shadow_len-1];
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input int pos, input logic [31:0] value);
        t_list_cmd c;
        c.cmd = cmd;
        c.pos = pos[4:0];
        c.value = value;
        cmd_q.push_back(c);
    endtask

    // command driver: inputs change on the falling edge
    always @(negedge i_clk) begin : drive_cmds
        t_list_cmd nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || cmd_taken) begin
            cmd_taken = 1'b0;
            // no gaps while the receiver holds off, so the block backs up
            if (cmd_gap > 0 && !hold_off) begin
                cmd_gap--;
                i_in_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                nxt = cmd_q.pop_front();
                i_cmd <= nxt.cmd;
                i_position <= nxt.pos;
                i_value <= nxt.value;
                i_in_valid <= 1'b1;
                if (idling_on(cmd_q.size()) && $urandom_range(0, 5) == 0)
                    cmd_gap = $urandom_range(1, 13);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver: ready stalls in bursts, or for the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_out_ready <= 1'b0;
        end else if (view_stall > 0) begin
            view_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idling_on(cmd_q.size()) && $urandom_range(0, 5) == 0)
                view_stall = $urandom_range(1, 13);
        end
    end

    // predict at the accept edge of every command item
    always @(posedge i_clk) begin : predict_views
        t_list_cmd  c;
        t_list_view v;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            c.cmd = i_cmd;
            c.pos = i_position;
            c.value = i_value;
            apply_list_cmd(c, v);
            view_q.push_back(v);
            cmd_taken = 1'b1;
            n_cmds++;
        end
    end

    // compare every accepted result item with the oldest owed view
    always @(posedge i_clk) begin : check_views
        t_list_view want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_views++;
            if (view_q.size() == 0) begin
                if (n_mismatch < 10)
                    $display("unexpected result: status %0d length %0d head %0d tail %0d",
                             o_status, o_length, o_head_value, o_tail_value);
                n_mismatch++;
            end else begin
                want = view_q.pop_front();
                n_status[want.status]++;
                if (o_status !== want.status || o_length !== want.length ||
                    o_head_value !== want.head || o_tail_value !== want.tail) begin
                    if (n_mismatch < 10)
                        $display({"result %0d mismatch: expected status %0d length %0d ",
                                  "head %0d tail %0d, got status %0d length %0d ",
                                  "head %0d tail %0d"},
                                 n_views, want.status, want.length, want.head, want.tail,
                                 o_status, o_length, o_head_value, o_tail_value);
                    n_mismatch++;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles here, once the run is under way
    initial begin
        while (n_views < 150) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (60) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // safety net against a hung handshake
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : main
        int ph;
        int k;
        int ins_pct;
        int pos;
        logic [1:0] cmd;
        logic [31:0] val;

        // directed: empty list, every command, bad positions, tail and only-entry deletes
        push_cmd(CMD_DELETE_AT, 1, 32'h0000_0001);      // delete from empty list
        push_cmd(CMD_INSERT_AT, 0, 32'h1234_5678);      // position zero on insert
        push_cmd(CMD_INSERT_AT, 1, 32'h8000_0000);      // positional insert into empty list
        push_cmd(CMD_INSERT_HEAD, 0, 32'h7fff_ffff);
        push_cmd(CMD_INSERT_TAIL, 0, 32'hffff_ffff);
        push_cmd(CMD_INSERT_AT, 4, 32'h0000_0000);      // length+1 appends at the tail
        push_cmd(CMD_INSERT_AT, 31, 32'h5555_aaaa);     // beyond length+1
        push_cmd(CMD_DELETE_AT, 0, 32'h0);              // position zero on delete
        push_cmd(CMD_DELETE_AT, 31, 32'hffff_ffff);     // beyond length
        push_cmd(CMD_DELETE_AT, 4, 32'h0);              // delete the tail entry
        push_cmd(CMD_DELETE_AT, 1, 32'h0);              // delete the head entry
        push_cmd(CMD_DELETE_AT, 1, 32'h0);
        push_cmd(CMD_DELETE_AT, 1, 32'h0);              // only entry: list goes empty
        // fill to capacity with a mix of inserts, then knock on a full list
        for (k = 0; k < LIST_DEPTH; k++) begin
            case (k % 3)
                0: push_cmd(CMD_INSERT_TAIL, 0, $urandom);
                1: push_cmd(CMD_INSERT_HEAD, 0, $urandom);
                default: push_cmd(CMD_INSERT_AT, (k / 2) + 1, $urandom);
            endcase
        end
        push_cmd(CMD_INSERT_HEAD, 1, 32'h0);
        push_cmd(CMD_INSERT_TAIL, 1, 32'h0);
        push_cmd(CMD_INSERT_AT, 31, 32'h0);             // full is reported before bad position

        // random: phases leaning toward filling, churning or draining the list
        for (ph = 0; ph < 13; ph++) begin
            case ((ph == 0) ? 0 : $urandom_range(0, 2))
                0: ins_pct = 80;
                1: ins_pct = 50;
                default: ins_pct = 20;
            endcase
            for (k = 0; k < 40; k++) begin
                if ($urandom_range(0, 99) < ins_pct) begin
                    case ($urandom_range(0, 2))
                        0: cmd = CMD_INSERT_HEAD;
                        1: cmd = CMD_INSERT_TAIL;
                        default: cmd = CMD_INSERT_AT;
                    endcase
                end else begin
                    cmd = CMD_DELETE_AT;
                end
                // small positions keep most commands legal, the rest probe the range
                case ($urandom_range(0, 19))
                    0, 1, 2: pos = $urandom_range(0, 31);
                    3, 4, 5, 6, 7: pos = $urandom_range(0, 17);
                    default: pos = $urandom_range(1, 4);
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: val = 32'h8000_0000;
                        1: val = 32'h7fff_ffff;
                        2: val = 32'h0000_0000;
                        default: val = 32'hffff_ffff;
                    endcase
                end else begin
                    val = $urandom;
                end
                push_cmd(cmd, pos, val);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all items offered and taken, then every owed result seen
        while (cmd_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (view_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("ran %0d commands, checked %0d results, peak length %0d",
                 n_cmds, n_views, peak_len);
        $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d; mismatches %0d",
                 n_status[ST_OK], n_status[ST_FULL], n_status[ST_EMPTY],
                 n_status[ST_BAD_POS], n_mismatch);
        if (n_mismatch == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/pol_pkg.sv
src/pol_cell.sv
src/positional_ordered_list_unit.sv
dv/positional_ordered_list_unit_tb.sv
